@@ design/caltc_pkg.sv @@
package caltc_pkg;

  localparam int Segments = 5;
  localparam int NPoints  = Segments + 1;
  localparam int SegW     = (Segments > 1) ? $clog2(Segments) : 1;
  localparam int FracBits = 16;

  localparam int VoltW  = 18;
  localparam int TempW  = 15;
  localparam int PtW    = 27;
  localparam int NumW   = 35;
  localparam int DenW   = TempW + 2;
  localparam int RawW   = 35;
  localparam int RefW   = 21;
  localparam int EcW    = 32;
  localparam int SlopeW = 32;
  localparam int HalfW  = SlopeW / 2;
  localparam int ProdW  = EcW + HalfW;
  localparam int FullW  = EcW + SlopeW;
  localparam int ScW    = FullW - FracBits;
  localparam int OfsW   = 40;
  localparam int YW     = ScW + 2;
  localparam int DvdW   = 52;
  localparam int DvsW   = 27;
  localparam int DivSteps = 4;
  localparam int DivCycles = DvdW / DivSteps;
  localparam int DivCntW = $clog2(DivCycles + 1);
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 27;
  localparam int StatW   = 3;
  localparam int SegOutW = 3;

  localparam logic [CfgIdxW-1:0] CfgOpenV = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPtA   = 3'd1;

  localparam logic [StatW-1:0] StOk    = 3'd0;
  localparam logic [StatW-1:0] StAbove = 3'd1;
  localparam logic [StatW-1:0] StSat   = 3'd2;
  localparam logic [StatW-1:0] StBad   = 3'd3;
  localparam logic [StatW-1:0] StNeg   = 3'd4;

  localparam logic [VoltW-1:0] OpenVReset = 18'd197000;

  typedef struct packed {
    logic                   above;
    logic                   zero;
    logic [NumW-1:0]        num;
    logic [VoltW-1:0]       volt;
    logic signed [DenW-1:0] den;
  } item_t;

  typedef logic [NPoints-1:0][PtW-1:0] pts_t;

  function automatic logic [RefW-1:0] ref_val(input int i);
    logic [RefW-1:0] r;
    case (i)
      0:       r = 21'd14100;
      1:       r = 21'd23500;
      2:       r = 21'd47200;
      3:       r = 21'd141300;
      4:       r = 21'd300000;
      default: r = 21'd1288000;
    endcase
    return r;
  endfunction

  function automatic logic [PtW-1:0] pt_reset(input int i);
    logic [PtW-1:0] r;
    case (i)
      0:       r = 27'd13900;
      1:       r = 27'd24900;
      2:       r = 27'd50000;
      3:       r = 27'd106500;
      4:       r = 27'd260100;
      default: r = 27'd611400;
    endcase
    return r;
  endfunction

endpackage

@@ design/caltc_front.sv @@
module caltc_front import caltc_pkg::*; (
  input  logic [VoltW-1:0] volt_i,
  input  logic [TempW-1:0] temp_i,
  input  logic [VoltW-1:0] open_v_i,
  output item_t            item_o
);

  logic [VoltW-1:0] diff;

  always_comb begin
    diff = open_v_i - volt_i;
    item_o.above = (volt_i > open_v_i);
    item_o.zero  = (volt_i == '0);
    item_o.volt  = volt_i;
    item_o.num   = item_o.above ? '0 : (NumW'(diff) * NumW'(100000));
    item_o.den   = $signed({temp_i[TempW-1], temp_i, 1'b0}) + DenW'(5000);
  end

endmodule

@@ design/caltc_fifo.sv @@
module caltc_fifo import caltc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t data_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ design/caltc_div.sv @@
module caltc_div import caltc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quot_o
);

  logic [DvsW:0]    rem_q, rem_n;
  logic [DvdW-1:0]  quo_q, quo_n;
  logic [DvsW-1:0]  dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic             busy_q, done_q;

  assign done_o = done_q;
  assign quot_o = quo_q;

  always_comb begin
    rem_n = rem_q;
    quo_n = quo_q;
    for (int i = 0; i < DivSteps; i++) begin
      rem_n = {rem_n[DvsW-1:0], quo_n[DvdW-1]};
      quo_n = {quo_n[DvdW-2:0], 1'b0};
      if (rem_n >= {1'b0, dvs_q}) begin
        rem_n    = rem_n - {1'b0, dvs_q};
        quo_n[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivCycles);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
  end

endmodule

@@ design/caltc_back.sv @@
module caltc_back import caltc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_data_i,
  output logic              q_pop_o,
  input  pts_t              pts_i,
  input  logic              derive_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EcW-1:0]    cal_o,
  output logic [EcW-1:0]    comp_o,
  output logic [SegOutW-1:0] seg_o,
  output logic [StatW-1:0]  status_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDiv1  = 4'd1;
  localparam logic [3:0] SDiv2  = 4'd2;
  localparam logic [3:0] SSel   = 4'd3;
  localparam logic [3:0] SMlo   = 4'd4;
  localparam logic [3:0] SMhi   = 4'd5;
  localparam logic [3:0] SScale = 4'd6;
  localparam logic [3:0] SYadd  = 4'd7;
  localparam logic [3:0] SOut   = 4'd8;
  localparam logic [3:0] SDseg  = 4'd9;
  localparam logic [3:0] SDdiv  = 4'd10;
  localparam logic [3:0] SDofs  = 4'd11;
  localparam logic [3:0] SDnext = 4'd12;

  localparam logic signed [YW-1:0] OfsHi = {{(YW-OfsW+1){1'b0}}, {(OfsW-1){1'b1}}};
  localparam logic signed [YW-1:0] OfsLo = ~OfsHi;
  localparam logic [DvdW-1:0] Max32 = {{(DvdW-EcW){1'b0}}, {EcW{1'b1}}};

  logic [3:0] state_q, state_d;
  logic       mode_q, mode_d, pend_q, pend_d;
  logic       inval_q, inval_d, pinv_q, pinv_d;
  item_t      item_q, item_d;
  logic [EcW-1:0] comp_q, comp_d;
  logic       sat_q, sat_d;
  logic [SegW-1:0] seg_q, seg_d, k_q, k_d;
  pts_t       win_q, win_d;
  logic [SlopeW-1:0] s_q, s_d;
  logic [ProdW-1:0]  p0_q, p0_d, p1_q, p1_d;
  logic [ScW-1:0]    sc_q, sc_d;
  logic signed [YW-1:0] y_q, y_d;
  logic [SlopeW-1:0] slope_q [Segments];
  logic [OfsW-1:0]   ofs_q [Segments];
  logic       wr_en;
  logic [SlopeW-1:0] wr_slope;
  logic [OfsW-1:0]   wr_ofs;
  logic       ov_q, ov_d;
  logic [EcW-1:0] cal_q, cal_d, oc_q, oc_d;
  logic [SegOutW-1:0] os_q, os_d;
  logic [StatW-1:0] st_q, st_d;

  logic            div_start, div_done;
  logic [DvdW-1:0] div_dvd, div_quot;
  logic [DvsW-1:0] div_dvs;

  logic [EcW-1:0]    mul_a;
  logic [SlopeW-1:0] mul_b;
  logic [FullW-1:0]  full;
  logic [RawW-1:0]   raw;
  logic [RefW-1:0]   r0, r1;
  logic signed [YW-1:0] ofs_full;
  logic            yneg, ysat;

  caltc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o = ov_q;
  assign cal_o       = cal_q;
  assign comp_o      = oc_q;
  assign seg_o       = os_q;
  assign status_o    = st_q;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    pend_d  = pend_q | derive_req_i;
    inval_d = inval_q;
    pinv_d  = pinv_q;
    item_d  = item_q;
    comp_d  = comp_q;
    sat_d   = sat_q;
    seg_d   = seg_q;
    k_d     = k_q;
    win_d   = win_q;
    s_d     = s_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    sc_d    = sc_q;
    y_d     = y_q;
    ov_d    = ov_q & ~out_ready_i;
    cal_d   = cal_q;
    oc_d    = oc_q;
    os_d    = os_q;
    st_d    = st_q;
    q_pop_o = 1'b0;
    div_start = 1'b0;
    div_dvd = '0;
    div_dvs = '0;
    wr_en   = 1'b0;
    wr_slope = '0;
    wr_ofs  = '0;
    raw     = div_quot[RawW-1:0];
    r0      = ref_val(int'(k_q));
    r1      = ref_val(int'(k_q) + 1);
    mul_a   = mode_q ? EcW'(win_q[0]) : comp_q;
    mul_b   = mode_q ? s_q : slope_q[seg_q];
    full    = FullW'(p0_q) + (FullW'(p1_q) << HalfW);
    ofs_full = $signed({{(YW-RefW){1'b0}}, r0}) - $signed({2'b00, sc_q});
    yneg    = y_q[YW-1];
    ysat    = !yneg && (y_q[YW-1:EcW] != '0);

    unique case (state_q)
      SIdle: begin
        if (pend_q) begin
          pend_d  = derive_req_i;
          mode_d  = 1'b1;
          win_d   = pts_i;
          k_d     = '0;
          inval_d = 1'b0;
          state_d = SDseg;
        end else if (q_valid_i) begin
          q_pop_o = 1'b1;
          mode_d  = 1'b0;
          item_d  = q_data_i;
          sat_d   = 1'b0;
          if (q_data_i.above) begin
            comp_d  = '0;
            state_d = SSel;
          end else if (q_data_i.zero) begin
            comp_d  = '1;
            sat_d   = 1'b1;
            state_d = SSel;
          end else begin
            div_start = 1'b1;
            div_dvd   = DvdW'(q_data_i.num);
            div_dvs   = DvsW'(q_data_i.volt);
            state_d   = SDiv1;
          end
        end
      end
      SDiv1: begin
        if (div_done) begin
          if (raw == '0) begin
            comp_d  = '0;
            state_d = SSel;
          end else if (item_q.den[DenW-1] || item_q.den == '0) begin
            comp_d  = '1;
            sat_d   = 1'b1;
            state_d = SSel;
          end else begin
            div_start = 1'b1;
            div_dvd   = DvdW'(raw) * DvdW'(10000);
            div_dvs   = DvsW'(unsigned'(item_q.den));
            state_d   = SDiv2;
          end
        end
      end
      SDiv2: begin
        if (div_done) begin
          if (div_quot > Max32) begin
            comp_d = '1;
            sat_d  = 1'b1;
          end else begin
            comp_d = div_quot[EcW-1:0];
          end
          state_d = SSel;
        end
      end
      SSel: begin
        seg_d = SegW'(Segments - 1);
        for (int k = Segments - 2; k >= 0; k--) begin
          if (comp_q < EcW'(pts_i[k+1])) seg_d = SegW'(k);
        end
        state_d = SMlo;
      end
      SMlo: begin
        p0_d    = ProdW'(mul_a) * ProdW'(mul_b[HalfW-1:0]);
        state_d = SMhi;
      end
      SMhi: begin
        p1_d    = ProdW'(mul_a) * ProdW'(mul_b[SlopeW-1:HalfW]);
        state_d = SScale;
      end
      SScale: begin
        sc_d    = ScW'(full >> FracBits);
        state_d = mode_q ? SDofs : SYadd;
      end
      SYadd: begin
        y_d = $signed({2'b00, sc_q}) + YW'($signed(ofs_q[seg_q]));
        state_d = SOut;
      end
      SOut: begin
        if (!ov_q || out_ready_i) begin
          ov_d  = 1'b1;
          oc_d  = comp_q;
          os_d  = SegOutW'(seg_q);
          cal_d = yneg ? '0 : (ysat ? '1 : y_q[EcW-1:0]);
          if (pinv_q) st_d = StBad;
          else if (sat_q || ysat) st_d = StSat;
          else if (yneg) st_d = StNeg;
          else if (item_q.above) st_d = StAbove;
          else st_d = StOk;
          state_d = SIdle;
        end
      end
      SDseg: begin
        if (win_q[1] <= win_q[0]) begin
          inval_d  = 1'b1;
          wr_en    = 1'b1;
          wr_slope = '0;
          wr_ofs   = OfsW'(r0);
          state_d  = SDnext;
        end else begin
          div_start = 1'b1;
          div_dvd   = DvdW'(r1 - r0) << FracBits;
          div_dvs   = DvsW'(win_q[1] - win_q[0]);
          state_d   = SDdiv;
        end
      end
      SDdiv: begin
        if (div_done) begin
          s_d     = (div_quot > Max32) ? '1 : div_quot[SlopeW-1:0];
          state_d = SMlo;
        end
      end
      SDofs: begin
        wr_en    = 1'b1;
        wr_slope = s_q;
        if (ofs_full < OfsLo) wr_ofs = OfsLo[OfsW-1:0];
        else if (ofs_full > OfsHi) wr_ofs = OfsHi[OfsW-1:0];
        else wr_ofs = ofs_full[OfsW-1:0];
        state_d = SDnext;
      end
      SDnext: begin
        for (int i = 0; i < NPoints - 1; i++) win_d[i] = win_q[i+1];
        if (k_q == SegW'(Segments - 1)) begin
          pinv_d  = inval_q;
          mode_d  = 1'b0;
          state_d = SIdle;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = SDseg;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      mode_q  <= 1'b0;
      pend_q  <= 1'b1;
      inval_q <= 1'b0;
      pinv_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      inval_q <= inval_d;
      pinv_q  <= pinv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    comp_q <= comp_d;
    sat_q  <= sat_d;
    seg_q  <= seg_d;
    k_q    <= k_d;
    win_q  <= win_d;
    s_q    <= s_d;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    sc_q   <= sc_d;
    y_q    <= y_d;
    cal_q  <= cal_d;
    oc_q   <= oc_d;
    os_q   <= os_d;
    st_q   <= st_d;
    if (wr_en) begin
      slope_q[k_q] <= wr_slope;
      ofs_q[k_q]   <= wr_ofs;
    end
  end

endmodule

@@ design/conductivity_calibration_core.sv @@
// Transactions are worked on one at a time, using the shared divider, which retires four
// quotient bits per cycle while it is busy.
// Input transactions are taken into a two-entry queue while earlier ones are worked on.
// After reset, and after every calibration point write, the line slopes and offsets
// are derived again; queued transactions wait for that to finish.
// Asynchronous active-low reset restores control and config registers to defaults.
module conductivity_calibration_core import caltc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // sensor_voltage [17:0], temperature [32:18]
  input  logic [39:0]        s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // calibrated_ec [31:0], compensated_ec [63:32], segment [66:64], status [69:67]
  output logic [71:0]        m_axis_tdata_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic [VoltW-1:0] open_v_q;
  pts_t             pts_q;
  logic             derive_req;
  item_t            front_item, q_item;
  logic             q_full, q_valid, q_pop, push;
  logic [EcW-1:0]   cal, comp;
  logic [SegOutW-1:0] seg;
  logic [StatW-1:0] status;

  assign derive_req = cfg_we_i && (cfg_idx_i >= CfgPtA) && (cfg_idx_i <= CfgIdxW'(6));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_v_q <= OpenVReset;
      for (int i = 0; i < NPoints; i++) pts_q[i] <= pt_reset(i);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgOpenV) open_v_q <= cfg_data_i[VoltW-1:0];
      for (int i = 0; i < NPoints; i++) begin
        if (i < 6 && cfg_idx_i == CfgIdxW'(i + 1)) pts_q[i] <= cfg_data_i[PtW-1:0];
      end
    end
  end

  caltc_front u_front (
    .volt_i   (s_axis_tdata_i[VoltW-1:0]),
    .temp_i   (s_axis_tdata_i[VoltW+TempW-1:VoltW]),
    .open_v_i (open_v_q),
    .item_o   (front_item)
  );

  assign s_axis_tready_o = !q_full;
  assign push = s_axis_tvalid_i && !q_full;

  caltc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_item)
  );

  caltc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_item),
    .q_pop_o      (q_pop),
    .pts_i        (pts_q),
    .derive_req_i (derive_req),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .cal_o        (cal),
    .comp_o       (comp),
    .seg_o        (seg),
    .status_o     (status)
  );

  assign m_axis_tdata_o = {2'b00, status, seg, comp, cal};

endmodule

@@ verif/conductivity_calibration_checker.sv @@
`timescale 1ns / 1ps

module conductivity_calibration_checker import caltc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [39:0]        s_axis_tdata_i,
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [71:0]        m_axis_tdata_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [2:0]       seg;
    logic [31:0]      comp;
    logic [31:0]      cal;
  } ec_reading_t;

  localparam logic [63:0] Max32 = 64'hFFFF_FFFF;
  localparam longint OfsMax = 64'sd549755813887;
  localparam longint OfsMin = -64'sd549755813888;

  logic [20:0]  ref_ec [NPoints];
  logic [17:0]  open_v;
  logic [26:0]  cal_pt [NPoints];
  logic [31:0]  line_slope [Segments];
  longint       line_ofs [Segments];
  logic         pts_bad;
  ec_reading_t  readings_due [$];

  initial begin
    ref_ec[0] = 21'd14100;
    ref_ec[1] = 21'd23500;
    ref_ec[2] = 21'd47200;
    ref_ec[3] = 21'd141300;
    ref_ec[4] = 21'd300000;
    ref_ec[5] = 21'd1288000;
  end

  function automatic void build_lines();
    logic [63:0] lo, hi, s;
    longint ofs;
    pts_bad = 1'b0;
    for (int k = 0; k < Segments; k++) begin
      lo = 64'(cal_pt[k]);
      hi = 64'(cal_pt[k+1]);
      if (hi <= lo) begin
        pts_bad = 1'b1;
        line_slope[k] = '0;
        line_ofs[k] = longint'(ref_ec[k]);
      end else begin
        s = (64'(ref_ec[k+1] - ref_ec[k]) << FracBits) / (hi - lo);
        if (s > Max32) s = Max32;
        line_slope[k] = s[31:0];
        ofs = longint'(ref_ec[k]) - longint'((lo * s) >> FracBits);
        if (ofs < OfsMin) ofs = OfsMin;
        if (ofs > OfsMax) ofs = OfsMax;
        line_ofs[k] = ofs;
      end
    end
  endfunction

  function automatic ec_reading_t calibrate(logic [17:0] v, logic signed [14:0] t);
    ec_reading_t r;
    logic above, sat, neg;
    logic [63:0] raw, comp;
    longint den, y;
    int seg;
    above = 1'b0;
    sat = 1'b0;
    neg = 1'b0;
    if (v > open_v) begin
      above = 1'b1;
      comp = 0;
    end else if (v == 0) begin
      sat = 1'b1;
      comp = Max32;
    end else begin
      raw = (64'd100000 * 64'(open_v - v)) / 64'(v);
      den = 2 * longint'(t) + 5000;
      if (raw == 0) begin
        comp = 0;
      end else if (den <= 0) begin
        sat = 1'b1;
        comp = Max32;
      end else begin
        comp = (raw * 64'd10000) / 64'(den);
        if (comp > Max32) begin
          sat = 1'b1;
          comp = Max32;
        end
      end
    end
    seg = Segments - 1;
    for (int k = Segments - 2; k >= 0; k--)
      if (comp < 64'(cal_pt[k+1])) seg = k;
    y = longint'((comp * 64'(line_slope[seg])) >> FracBits) + line_ofs[seg];
    if (y < 0) begin
      neg = 1'b1;
      r.cal = '0;
    end else if (y > longint'(Max32)) begin
      sat = 1'b1;
      r.cal = '1;
    end else begin
      r.cal = y[31:0];
    end
    r.comp = comp[31:0];
    r.seg = 3'(seg);
    if (pts_bad) r.status = StBad;
    else if (sat) r.status = StSat;
    else if (neg) r.status = StNeg;
    else if (above) r.status = StAbove;
    else r.status = StOk;
    return r;
  endfunction

  assign pending_o = readings_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ec_reading_t want, got;
    if (!rst_ni) begin
      open_v = OpenVReset;
      cal_pt[0] = 27'd13900;
      cal_pt[1] = 27'd24900;
      cal_pt[2] = 27'd50000;
      cal_pt[3] = 27'd106500;
      cal_pt[4] = 27'd260100;
      cal_pt[5] = 27'd611400;
      build_lines();
      readings_due.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgOpenV) begin
          open_v = cfg_data_i[17:0];
        end else if (cfg_idx_i <= CfgPtA + 3'(NPoints - 1)) begin
          cal_pt[cfg_idx_i - CfgPtA] = cfg_data_i;
          build_lines();
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        readings_due.push_back(calibrate(s_axis_tdata_i[17:0], s_axis_tdata_i[32:18]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[69:0];
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors_o++;
        end else begin
          want = readings_due.pop_front();
          if (got.cal !== want.cal) begin
            $display("%0t: calibrated_ec expected %0d got %0d", $time, want.cal, got.cal);
            errors_o++;
          end
          if (got.comp !== want.comp) begin
            $display("%0t: compensated_ec expected %0d got %0d", $time, want.comp, got.comp);
            errors_o++;
          end
          if (got.seg !== want.seg) begin
            $display("%0t: segment expected %0d got %0d", $time, want.seg, got.seg);
            errors_o++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import caltc_pkg::*;

  localparam int StallLimit = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [39:0]        s_axis_tdata_i = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [71:0]        m_axis_tdata_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  int                 errors;
  int                 pending;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  bit                 long_hold = 1'b0;
  int                 quiet_cycles = 0;
  logic [17:0]        cur_open_v = OpenVReset;

  always #1 clk_i = ~clk_i;

  conductivity_calibration_core uut (.*);

  conductivity_calibration_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_reading(logic [17:0] v, logic [14:0] t);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, t, v};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [26:0] vals [7]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= (i < 7) ? vals[i] : 27'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_open_v = vals[0][17:0];
  endtask

  task automatic random_reading();
    logic [17:0] v;
    logic [14:0] t;
    case ($urandom_range(9))
      0:       v = 18'($urandom);
      1:       v = 18'($urandom_range(3));
      2:       v = cur_open_v + 18'($urandom_range(3)) - 18'd1;
      3:       v = 18'($urandom_range(204800, 262143));
      default: v = 18'($urandom_range(1, 204800));
    endcase
    case ($urandom_range(9))
      0:       t = 15'($urandom);
      1:       t = 15'(-2500 + $urandom_range(4) - 2);
      default: t = 15'($urandom_range(12000) - 2000);
    endcase
    send_reading(v, t);
  endtask

  initial begin
    logic [26:0] regs [7];
    logic [14:0] dir_t [6];
    logic [17:0] dir_v [13];
    int acc;
    dir_t = '{15'd2500, 15'd10000, -15'sd2000, -15'sd2500, 15'h4000, 15'h3FFF};
    dir_v = '{18'd0, 18'd1, 18'd197000, 18'd197001, 18'h3FFFF, 18'd204800,
              18'd180000, 18'd150000, 18'd120000, 18'd90000, 18'd50000, 18'd20000, 18'd5000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_v[i]) send_reading(dir_v[i], dir_t[i % 6]);
    foreach (dir_t[i]) send_reading(18'd100000, dir_t[i]);
    send_reading(18'd197000, -15'sd3000);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          regs[0] = 27'($urandom_range(150000, 204800));
          acc = $urandom_range(5000);
          for (int i = 1; i < 7; i++) begin
            regs[i] = 27'(acc);
            acc += $urandom_range(1, 300000);
          end
          tx_idle_pct = 18;
          rx_idle_pct = 80;
        end
        1: begin
          regs[0] = 27'd204800;
          for (int i = 1; i < 7; i++) regs[i] = 27'($urandom);
          regs[3] = regs[2];
          tx_idle_pct = 80;
          rx_idle_pct = 18;
        end
        default: begin
          regs[0] = 27'd0;
          regs[1] = 27'd0;
          regs[2] = 27'd1;
          regs[3] = 27'd2;
          regs[4] = 27'd40000000;
          regs[5] = 27'd100000000;
          regs[6] = 27'h7FFFFFF;
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_regs(regs);
      for (int n = 0; n < 590; n++) begin
        if (phase == 2 && n == 10) long_hold = 1'b1;
        if (phase == 2 && n == 300) begin
          drain();
          regs[0] = 27'd197000;
          regs[1] = 27'd13900;
          regs[2] = 27'd24900;
          regs[3] = 27'd50000;
          regs[4] = 27'd106500;
          regs[5] = 27'd260100;
          regs[6] = 27'd611400;
          write_regs(regs);
        end
        random_reading();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
